// ----- rtl/uvc_pp_pkg.sv -----
// ----------------------------------------------------------------------------
// uvc_pp_pkg: shared types and constants of the UVC payload packetizer
// Field widths, header codes, status codes, register indexes and the result
// bundle passed from the packet engine to the output serializer.
// ----------------------------------------------------------------------------
package uvc_pp_pkg;

   localparam int FRAME_LEN_W = 24;
   localparam int BYTE_W      = 8;
   localparam int MAXPKT_W    = 11;
   localparam int CSR_IDX_W   = 8;
   localparam int RES_MAX     = 3;
   localparam int RES_CNT_W   = 2;
   localparam int RES_IDX_W   = 2;

   // request modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_DATA  = 1'b1;

   // payload header
   localparam logic [BYTE_W-1:0]   HDR_LEN       = 8'd2;
   localparam int                  FLAG_FID_BIT  = 0;
   localparam int                  FLAG_EOF_BIT  = 1;
   localparam logic [MAXPKT_W-1:0] MAXPKT_MIN    = 11'd3;
   localparam logic [MAXPKT_W-1:0] MAXPKT_RESET  = 11'd512;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_ENABLE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PACKET    = 8'd1;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_BUSY  = 2'd1,
      STAT_STRAY = 2'd2
   } status_type;

   typedef struct packed {
      logic                stream_enable;
      logic [MAXPKT_W-1:0] max_packet_bytes;
   } cfg_type;

   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              packet_last;
      status_type        status;
   } res_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]      count;
      res_type [RES_MAX-1:0]     ent;
   } bundle_type;

endpackage

// ----- rtl/uvc_pp_engine.sv -----
// ----------------------------------------------------------------------------
// uvc_pp_engine: frame and packet state with single-pass result builder
// Turns one registered request into a bundle of one to three result bytes
// and advances the frame state when the bundle is handed on.
// ----------------------------------------------------------------------------
module uvc_pp_engine #(
   parameter int LENGTH_WIDTH = 24,
   parameter int MAX_PACKET   = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic                                mode,
   input  logic [uvc_pp_pkg::FRAME_LEN_W-1:0]  frame_length,
   input  logic [uvc_pp_pkg::BYTE_W-1:0]       data_byte,
   input  uvc_pp_pkg::cfg_type                 cfg,
   output uvc_pp_pkg::bundle_type              bundle
);
   import uvc_pp_pkg::*;

   localparam int PIP_W = $clog2(MAX_PACKET);

   logic [LENGTH_WIDTH-1:0] rem_ff, rem_in;
   logic [PIP_W-1:0]        pip_ff, pip_in;
   logic                    fid_ff, fid_in;
   logic                    active_ff, active_in;

   logic [31:0]             len_wide;
   logic [LENGTH_WIDTH-1:0] len;
   logic [MAXPKT_W-1:0]     mp;
   logic [PIP_W-1:0]        cap;
   logic [LENGTH_WIDTH-1:0] hdr_rem;
   logic [BYTE_W-1:0]       flags;
   res_type                 hdr0, hdr1, dat;
   logic                    need_hdr;
   logic [PIP_W-1:0]        pip_next;
   logic [LENGTH_WIDTH-1:0] rem_next;

   assign len_wide = {{(32 - FRAME_LEN_W){1'b0}}, frame_length};
   assign len      = len_wide[LENGTH_WIDTH-1:0];

   always_comb begin
      // clamp packet size, payload capacity excludes the header
      mp = cfg.max_packet_bytes;
      if (mp < MAXPKT_MIN) begin
         mp = MAXPKT_MIN;
      end else if (mp > MAXPKT_W'(MAX_PACKET)) begin
         mp = MAXPKT_W'(MAX_PACKET);
      end
      cap = PIP_W'(mp - MAXPKT_W'(HDR_LEN));

      hdr_rem = (mode == MODE_START) ? len : rem_ff;
      flags = '0;
      flags[FLAG_FID_BIT] = fid_ff;
      flags[FLAG_EOF_BIT] = (hdr_rem <= LENGTH_WIDTH'(cap));
      hdr0 = '{byte_valid: 1'b1, out_byte: HDR_LEN, packet_last: 1'b0, status: STAT_OK};
      hdr1 = '{byte_valid: 1'b1, out_byte: flags,
               packet_last: (hdr_rem == '0), status: STAT_OK};

      need_hdr = (pip_ff >= cap);
      pip_next = (need_hdr ? '0 : pip_ff) + PIP_W'(1);
      rem_next = rem_ff - LENGTH_WIDTH'(1);
      dat = '{byte_valid: 1'b1, out_byte: data_byte,
              packet_last: (pip_next >= cap) || (rem_next == '0), status: STAT_OK};

      rem_in    = rem_ff;
      pip_in    = pip_ff;
      fid_in    = fid_ff;
      active_in = active_ff;
      bundle    = '0;
      bundle.count = RES_CNT_W'(1);

      case (mode)
         MODE_START: begin
            if (!cfg.stream_enable || active_ff) begin
               bundle.ent[0].status = STAT_BUSY;
            end else begin
               bundle.count  = RES_CNT_W'(2);
               bundle.ent[0] = hdr0;
               bundle.ent[1] = hdr1;
               rem_in = len;
               pip_in = '0;
               if (len == '0) begin
                  fid_in    = ~fid_ff;
                  active_in = 1'b0;
               end else begin
                  active_in = 1'b1;
               end
            end
         end
         default: begin
            if (!active_ff) begin
               bundle.ent[0].status = STAT_STRAY;
            end else begin
               if (need_hdr) begin
                  bundle.count  = RES_CNT_W'(3);
                  bundle.ent[0] = hdr0;
                  bundle.ent[1] = hdr1;
                  bundle.ent[2] = dat;
               end else begin
                  bundle.ent[0] = dat;
               end
               rem_in = rem_next;
               pip_in = pip_next;
               if (rem_next == '0) begin
                  active_in = 1'b0;
                  pip_in    = '0;
                  fid_in    = ~fid_ff;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         pip_ff    <= '0;
         fid_ff    <= 1'b0;
         active_ff <= 1'b0;
      end else if (go) begin
         rem_ff    <= rem_in;
         pip_ff    <= pip_in;
         fid_ff    <= fid_in;
         active_ff <= active_in;
      end
   end

endmodule

// ----- rtl/uvc_pp_serializer.sv -----
// ----------------------------------------------------------------------------
// uvc_pp_serializer: result register that plays out a bundle byte by byte
// Takes a new bundle in the cycle its last byte is taken.
// ----------------------------------------------------------------------------
module uvc_pp_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   output logic                   load_ready,
   input  uvc_pp_pkg::bundle_type load_bundle,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output uvc_pp_pkg::res_type    rsp_res,
   output logic                   rsp_run_last
);
   import uvc_pp_pkg::*;

   logic                 busy_ff, busy_in;
   logic [RES_IDX_W-1:0] idx_ff, idx_in;
   bundle_type           bundle_ff, bundle_in;
   logic                 last;
   logic                 load;

   assign last         = (idx_ff == RES_IDX_W'(bundle_ff.count - RES_CNT_W'(1)));
   assign load_ready   = !busy_ff || (rsp_ready && last);
   assign load         = load_valid && load_ready;
   assign rsp_valid    = busy_ff;
   assign rsp_res      = bundle_ff.ent[idx_ff];
   assign rsp_run_last = last;

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (load) begin
         busy_in   = 1'b1;
         idx_in    = '0;
         bundle_in = load_bundle;
      end else if (busy_ff && rsp_ready) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + RES_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

endmodule

// ----- rtl/uvc_payload_packetizer.sv -----
// ----------------------------------------------------------------------------
// uvc_payload_packetizer: splits video frames into UVC payload packets
// Frame-start requests open a frame and emit the packet header, data
// requests carry payload bytes; a new header goes out at each packet start.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_ready   mode, frame_length, data_byte
//   rsp_     out        rsp_valid/rsp_ready   byte_valid, out_byte,
//                                             packet_last, run_last, status
//   csr_     in         csr_valid/csr_ready   csr_index, csr_wdata
//
// A request waits in the input register, then its one to three result
// bytes leave the result register one per cycle while rsp_ready is high.
// A request yields one result when it is a plain data byte or a refusal,
// and two or three when a packet header goes out with it. Reset is
// synchronous and clears all frame state, the registers return to
// streaming off and a 512-byte packet size. A stalled rsp_ready holds
// the result register and backs up into req_ready.
//
module uvc_payload_packetizer #(
   parameter int LENGTH_WIDTH = 24,
   parameter int MAX_PACKET   = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [uvc_pp_pkg::FRAME_LEN_W-1:0]  req_frame_length,
   input  logic [uvc_pp_pkg::BYTE_W-1:0]       req_data_byte,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_byte_valid,
   output logic [uvc_pp_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                                rsp_packet_last,
   output logic                                rsp_run_last,
   output logic [1:0]                          rsp_status,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uvc_pp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [uvc_pp_pkg::MAXPKT_W-1:0]     csr_wdata
);
   import uvc_pp_pkg::*;

   // input register
   logic                   in_valid_ff, in_valid_in;
   logic                   mode_ff;
   logic [FRAME_LEN_W-1:0] len_ff;
   logic [BYTE_W-1:0]      data_ff;

   // configuration registers
   logic                   stream_enable_ff, stream_enable_in;
   logic [MAXPKT_W-1:0]    max_packet_ff, max_packet_in;

   cfg_type                cfg;
   bundle_type             bundle;
   logic                   load_ready;
   logic                   go;
   logic                   req_take;
   res_type                res;

   // Advance the input register whenever the serializer takes its bundle.
   assign go        = in_valid_ff && load_ready;
   assign req_ready = !in_valid_ff || load_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the payload until the next request lands.
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         len_ff  <= req_frame_length;
         data_ff <= req_data_byte;
      end
   end

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      stream_enable_in = stream_enable_ff;
      max_packet_in    = max_packet_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STREAM_ENABLE: stream_enable_in = csr_wdata[0];
            CSR_MAX_PACKET:    max_packet_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_enable_ff <= 1'b0;
         max_packet_ff    <= MAXPKT_RESET;
      end else begin
         stream_enable_ff <= stream_enable_in;
         max_packet_ff    <= max_packet_in;
      end
   end

   assign cfg.stream_enable    = stream_enable_ff;
   assign cfg.max_packet_bytes = max_packet_ff;

   uvc_pp_engine #(
      .LENGTH_WIDTH (LENGTH_WIDTH),
      .MAX_PACKET   (MAX_PACKET)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .mode         (mode_ff),
      .frame_length (len_ff),
      .data_byte    (data_ff),
      .cfg          (cfg),
      .bundle       (bundle)
   );

   uvc_pp_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (in_valid_ff),
      .load_ready   (load_ready),
      .load_bundle  (bundle),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_res      (res),
      .rsp_run_last (rsp_run_last)
   );

   assign rsp_byte_valid  = res.byte_valid;
   assign rsp_out_byte    = res.out_byte;
   assign rsp_packet_last = res.packet_last;
   assign rsp_status      = res.status;

`ifndef SYNTHESIS
   // A refused or stray request yields exactly one empty result.
   a_refusal_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_run_last && !rsp_byte_valid)
      else $error("refusal result is not a single empty result");

   // Packet end only on a carried byte.
   a_plast_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_last |-> rsp_byte_valid)
      else $error("packet_last without a packet byte");

   // A request is never dropped: a full input register with a blocked
   // serializer must keep its request.
   a_hold_request : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load_ready |=> in_valid_ff)
      else $error("pending request lost");

   // Reset empties the result register.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");
`endif

endmodule

// ----- tb/uvc_payload_packetizer_test.sv -----
// ----------------------------------------------------------------------------
// uvc_payload_packetizer_test: self-checking bench of the UVC payload packetizer
// A directed table walks refusals, stray bytes, zero-length frames, packet
// splits, size clamping and register changes inside a frame, then random
// frames follow. Every result byte is checked against typed-in results or an
// in-bench packetizer while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module uvc_payload_packetizer_test;
   import uvc_pp_pkg::*;

   localparam int MAX_PACKET    = 1024;
   localparam int RANDOM_ITEMS  = 420;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_LIMIT   = 5000;
   localparam int PRINT_LIMIT   = 100;
   // input register plus up to three result bytes
   localparam int BLOCK_LATENCY = 4;

   // one result byte as it appears on the rsp_ channel
   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              packet_last;
      logic              run_last;
      status_type        status;
   } pkt_byte_type;

   typedef enum {ROW_REQ, ROW_CSR} row_kind_type;

   // one row of the directed table: a request (possibly repeated with random
   // payload bytes) or a register write; nfix > 0 means typed-in results
   typedef struct {
      row_kind_type           kind;
      logic                   mode;
      logic [FRAME_LEN_W-1:0] len;
      logic [BYTE_W-1:0]      dbyte;
      logic [CSR_IDX_W-1:0]   idx;
      logic [MAXPKT_W-1:0]    wdata;
      int                     reps;
      int                     nfix;
      pkt_byte_type           fix [RES_MAX];
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic                   req_mode         = MODE_START;
   logic [FRAME_LEN_W-1:0] req_frame_length = '0;
   logic [BYTE_W-1:0]      req_data_byte    = '0;

   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic                   rsp_byte_valid;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_packet_last;
   logic                   rsp_run_last;
   logic [1:0]             rsp_status;

   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [MAXPKT_W-1:0]    csr_wdata        = '0;

   uvc_payload_packetizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_frame_length (req_frame_length),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_last  (rsp_packet_last),
      .rsp_run_last     (rsp_run_last),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Packetizer state kept by the bench: registers and frame progress
   // -------------------------------------------------------------------------
   logic                   stream_on;
   logic [MAXPKT_W-1:0]    pkt_size;
   logic [FRAME_LEN_W-1:0] remaining;
   logic [9:0]             pkt_fill;
   logic                   cur_fid;
   logic                   in_frame;

   // result bytes of the latest request, and all bytes still owed by the block
   pkt_byte_type pred_res [RES_MAX];
   int           pred_n;
   pkt_byte_type owed_bytes [$];

   plan_row_type plan [$];
   int        mismatch_count = 0;
   int        burst_left = 0;
   int        stall_mode = 0;
   int        stall_left = 0;
   int        idle_cycles = 0;

   // payload bytes per packet after clamping the packet size to 3..MAX_PACKET
   function automatic logic [MAXPKT_W-1:0] payload_capacity();
      logic [MAXPKT_W-1:0] p;
      p = pkt_size;
      if (p < MAXPKT_MIN) p = MAXPKT_MIN;
      if (p > MAXPKT_W'(MAX_PACKET)) p = MAXPKT_W'(MAX_PACKET);
      return p - MAXPKT_W'(HDR_LEN);
   endfunction

   function automatic void emit(logic vld, logic [BYTE_W-1:0] ob, logic pl, status_type st);
      pred_res[pred_n] = '{byte_valid: vld, out_byte: ob, packet_last: pl,
                           run_last: 1'b0, status: st};
      pred_n++;
   endfunction

   // length byte, then flags with the frame id and end-of-frame on the final packet
   function automatic void emit_header();
      logic [BYTE_W-1:0] flags;
      flags = '0;
      flags[FLAG_FID_BIT] = cur_fid;
      flags[FLAG_EOF_BIT] = (remaining <= FRAME_LEN_W'(payload_capacity()));
      emit(1'b1, HDR_LEN, 1'b0, STAT_OK);
      emit(1'b1, flags, remaining == '0, STAT_OK);
   endfunction

   // advance the frame state by one accepted request and fill pred_res
   function automatic void packetize(logic mode, logic [FRAME_LEN_W-1:0] len,
                                     logic [BYTE_W-1:0] dbyte);
      logic [MAXPKT_W-1:0] cap;
      pred_n = 0;
      cap = payload_capacity();
      if (mode == MODE_START) begin
         if (!stream_on || in_frame) begin
            emit(1'b0, '0, 1'b0, STAT_BUSY);
         end else begin
            remaining = len;
            pkt_fill = '0;
            emit_header();
            // a zero-length frame is complete with its header
            if (len == '0) cur_fid = ~cur_fid;
            else in_frame = 1'b1;
         end
      end else if (!in_frame) begin
         emit(1'b0, '0, 1'b0, STAT_STRAY);
      end else begin
         // close a full packet, including one left over-full by a size change
         if (MAXPKT_W'(pkt_fill) >= cap) begin
            pkt_fill = '0;
            emit_header();
         end
         pkt_fill = pkt_fill + 10'd1;
         remaining = remaining - 1'b1;
         emit(1'b1, dbyte, (MAXPKT_W'(pkt_fill) >= cap) || (remaining == '0), STAT_OK);
         if (remaining == '0) begin
            in_frame = 1'b0;
            pkt_fill = '0;
            cur_fid = ~cur_fid;
         end
      end
      pred_res[pred_n-1].run_last = 1'b1;
   endfunction

   function automatic void push_predicted();
      for (int k = 0; k < pred_n; k++) owed_bytes.push_back(pred_res[k]);
   endfunction

   // -------------------------------------------------------------------------
   // Directed table builders
   // -------------------------------------------------------------------------
   function automatic void add_req(logic mode, logic [FRAME_LEN_W-1:0] len,
                                   logic [BYTE_W-1:0] dbyte, int reps);
      plan_row_type r;
      r.kind  = ROW_REQ;
      r.mode  = mode;
      r.len   = len;
      r.dbyte = dbyte;
      r.idx   = '0;
      r.wdata = '0;
      r.reps  = reps;
      r.nfix  = 0;
      plan.push_back(r);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [MAXPKT_W-1:0] wdata);
      plan_row_type r;
      r.kind  = ROW_CSR;
      r.mode  = MODE_START;
      r.len   = '0;
      r.dbyte = '0;
      r.idx   = idx;
      r.wdata = wdata;
      r.reps  = 1;
      r.nfix  = 0;
      plan.push_back(r);
   endfunction

   // attach one typed-in result byte to the last request row
   function automatic void add_fix(logic vld, logic [BYTE_W-1:0] ob, logic pl, status_type st);
      plan_row_type r;
      r = plan.pop_back();
      r.fix[r.nfix] = '{byte_valid: vld, out_byte: ob, packet_last: pl,
                        run_last: 1'b0, status: st};
      r.nfix++;
      plan.push_back(r);
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic report(string what, int got, int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch %0s: got %0h want %0h", what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result(pkt_byte_type got);
      pkt_byte_type want;
      if (owed_bytes.size() == 0) begin
         report("result with nothing owed", int'(got), 0);
      end else begin
         want = owed_bytes.pop_front();
         if (got.byte_valid != want.byte_valid)
            report("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
         if (got.out_byte != want.out_byte)
            report("out_byte", int'(got.out_byte), int'(want.out_byte));
         if (got.packet_last != want.packet_last)
            report("packet_last", int'(got.packet_last), int'(want.packet_last));
         if (got.run_last != want.run_last)
            report("run_last", int'(got.run_last), int'(want.run_last));
         if (got.status != want.status)
            report("status", int'(got.status), int'(want.status));
      end
   endtask

   // compare every accepted result byte with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result('{byte_valid: rsp_byte_valid, out_byte: rsp_out_byte,
                        packet_last: rsp_packet_last, run_last: rsp_run_last,
                        status: status_type'(rsp_status)});
   end

   // receiver: switch between always ready, light and heavy random stalls and
   // a periodic stall, each for a stretch of random length
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 80);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= (stall_left % 4 != 0);
         end
      endcase
   end

   // watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[uvc_payload_packetizer] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // present one request, hold it until accepted, then advance the packetizer
   task automatic send_request(logic mode, logic [FRAME_LEN_W-1:0] len,
                               logic [BYTE_W-1:0] dbyte);
      int gap;
      gap = 0;
      // start a new burst, usually after a random gap
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_frame_length <= len;
      req_data_byte    <= dbyte;
      do @(posedge clock); while (!req_ready);
      packetize(mode, len, dbyte);
   endtask

   // write one register once the block has delivered everything it owes
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [MAXPKT_W-1:0] wdata);
      req_valid <= 1'b0;
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (BLOCK_LATENCY) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_STREAM_ENABLE) stream_on = wdata[0];
      else if (idx == CSR_MAX_PACKET) pkt_size = wdata;
   endtask

   // packet size: mostly small so packets split often, plus the clamped extremes
   function automatic logic [MAXPKT_W-1:0] pick_packet_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return MAXPKT_W'($urandom_range(3, 12));
      if (r < 75) return MAXPKT_W'($urandom_range(13, 70));
      if (r < 83) return MAXPKT_W'($urandom_range(0, 2));
      if (r < 91) return MAXPKT_W'(MAX_PACKET);
      if (r < 96) return MAXPKT_W'($urandom_range(MAX_PACKET + 1, 2047));
      return MAXPKT_W'($urandom_range(71, MAX_PACKET - 1));
   endfunction

   function automatic logic [FRAME_LEN_W-1:0] pick_frame_length();
      int r;
      r = $urandom_range(0, 99);
      // a refused start can carry any length
      if (!stream_on) return FRAME_LEN_W'($urandom());
      if (r < 12) return '0;
      if (r < 85) return FRAME_LEN_W'($urandom_range(1, 30));
      if (r < 97) return FRAME_LEN_W'($urandom_range(31, 200));
      return FRAME_LEN_W'($urandom_range(201, 1200));
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int sent;
      int n;
      logic mode;
      logic [FRAME_LEN_W-1:0] len;
      logic [BYTE_W-1:0] dbyte;

      stream_on = 1'b0;
      pkt_size  = MAXPKT_RESET;
      remaining = '0;
      pkt_fill  = '0;
      cur_fid   = 1'b0;
      in_frame  = 1'b0;

      // refusal with streaming off at the largest length, then stray bytes
      add_req(MODE_START, 24'hFFFFFF, 8'h00, 1);
      add_fix(1'b0, 8'h00, 1'b0, STAT_BUSY);
      add_req(MODE_DATA, 24'h000000, 8'hFF, 1);
      add_fix(1'b0, 8'h00, 1'b0, STAT_STRAY);
      add_req(MODE_DATA, 24'hFFFFFF, 8'h00, 1);
      add_fix(1'b0, 8'h00, 1'b0, STAT_STRAY);
      add_csr(CSR_STREAM_ENABLE, 11'h001);
      // two zero-length frames: header-only packets, frame id toggles
      add_req(MODE_START, 24'd0, 8'h00, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h02, 1'b1, STAT_OK);
      add_req(MODE_START, 24'd0, 8'hFF, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h03, 1'b1, STAT_OK);
      // reset packet size holds 510 payload bytes, so a short frame is one packet
      add_req(MODE_START, 24'd12, 8'h00, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h02, 1'b0, STAT_OK);
      add_req(MODE_START, 24'd1, 8'h00, 1);
      add_fix(1'b0, 8'h00, 1'b0, STAT_BUSY);
      // shrink to one payload byte per packet inside the frame
      add_csr(CSR_MAX_PACKET, 11'd3);
      add_req(MODE_DATA, 24'd0, 8'hFF, 1);
      add_fix(1'b1, 8'hFF, 1'b1, STAT_OK);
      add_req(MODE_DATA, 24'd0, 8'h00, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h00, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h00, 1'b1, STAT_OK);
      // grow past the top of the range inside the same packet, then finish the frame
      add_csr(CSR_MAX_PACKET, 11'h7FF);
      add_req(MODE_DATA, 24'd0, 8'h00, 9);
      add_req(MODE_DATA, 24'd0, 8'h5A, 1);
      add_fix(1'b1, 8'h5A, 1'b1, STAT_OK);
      // a size below the range clamps to three; streaming off mid-frame
      add_csr(CSR_MAX_PACKET, 11'd0);
      add_req(MODE_START, 24'd1, 8'h00, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h03, 1'b0, STAT_OK);
      add_csr(CSR_STREAM_ENABLE, 11'h7FE);
      add_req(MODE_DATA, 24'd0, 8'hA5, 1);
      add_fix(1'b1, 8'hA5, 1'b1, STAT_OK);
      add_req(MODE_START, 24'd2, 8'h00, 1);
      add_fix(1'b0, 8'h00, 1'b0, STAT_BUSY);
      add_csr(CSR_STREAM_ENABLE, 11'h001);
      add_csr(8'hFF, 11'h7FF);
      add_csr(CSR_MAX_PACKET, 11'd2);
      add_req(MODE_START, 24'd2, 8'h00, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h00, 1'b0, STAT_OK);
      add_req(MODE_DATA, 24'd0, 8'h00, 1);
      add_fix(1'b1, 8'h00, 1'b1, STAT_OK);
      add_req(MODE_DATA, 24'd0, 8'hFF, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h02, 1'b0, STAT_OK);
      add_fix(1'b1, 8'hFF, 1'b1, STAT_OK);
      // shrink below the current fill: the open packet closes on the next byte
      add_csr(CSR_MAX_PACKET, 11'd1025);
      add_req(MODE_START, 24'd3, 8'h00, 1);
      add_req(MODE_DATA, 24'd0, 8'h00, 2);
      add_csr(CSR_MAX_PACKET, 11'd3);
      add_req(MODE_DATA, 24'd0, 8'hC3, 1);
      add_fix(1'b1, HDR_LEN, 1'b0, STAT_OK);
      add_fix(1'b1, 8'h03, 1'b0, STAT_OK);
      add_fix(1'b1, 8'hC3, 1'b1, STAT_OK);

      // hold reset, then release it once
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_register(plan[i].idx, plan[i].wdata);
         end else begin
            for (int r = 0; r < plan[i].reps; r++) begin
               dbyte = (plan[i].reps > 1) ? BYTE_W'($urandom()) : plan[i].dbyte;
               send_request(plan[i].mode, plan[i].len, dbyte);
               if (plan[i].nfix > 0) begin
                  for (int k = 0; k < plan[i].nfix; k++) begin
                     pred_res[k] = plan[i].fix[k];
                     pred_res[k].run_last = (k == plan[i].nfix - 1);
                  end
                  pred_n = plan[i].nfix;
               end
               push_predicted();
            end
         end
      end

      // random phases: new register settings, then mostly well-formed frames;
      // frames may run across phases and so see register changes mid-frame
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1) == 0) begin
            write_register(CSR_MAX_PACKET, pick_packet_size());
            write_register(CSR_STREAM_ENABLE,
                           {(MAXPKT_W-1)'($urandom()), ($urandom_range(0, 99) < 85)});
         end else begin
            write_register(CSR_STREAM_ENABLE,
                           {(MAXPKT_W-1)'($urandom()), ($urandom_range(0, 99) < 85)});
            write_register(CSR_MAX_PACKET, pick_packet_size());
         end
         if ($urandom_range(0, 9) == 0)
            write_register(CSR_IDX_W'($urandom_range(2, 255)), MAXPKT_W'($urandom()));
         n = $urandom_range(15, 50);
         repeat (n) begin
            len   = FRAME_LEN_W'($urandom());
            dbyte = BYTE_W'($urandom());
            if (in_frame) begin
               // inside a frame: data bytes, now and then a refused start
               mode = ($urandom_range(0, 99) < 92) ? MODE_DATA : MODE_START;
            end else if ($urandom_range(0, 99) < 75) begin
               mode = MODE_START;
               len  = pick_frame_length();
            end else begin
               mode = MODE_DATA;
            end
            send_request(mode, len, dbyte);
            push_predicted();
            sent++;
         end
      end

      // drop the request line, drain, then let the pipeline settle
      req_valid <= 1'b0;
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[uvc_payload_packetizer] OK");
      end else begin
         $display("[uvc_payload_packetizer] ERROR");
      end
      $finish;
   end

endmodule
